### hdl/lcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcc_pkg
// Shared types and constants of the collision counter: register indexes,
// field widths and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package lcc_pkg;

  localparam int ID_W        = 16;
  localparam int CNT_CFG_W   = 7;
  localparam int TOTAL_W     = 17;
  localparam int CFG_AW      = 2;
  localparam int CFG_DW      = 17;
  localparam int OUT_TDATA_W = 40;

  localparam logic [CFG_AW-1:0] CFG_NUM_TABLES      = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_COUNT_THRESHOLD = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_CANDIDATE_LIMIT = 2'd2;

  localparam logic [CNT_CFG_W-1:0] NUM_TABLES_RST      = 7'd16;
  localparam logic [CNT_CFG_W-1:0] COUNT_THRESHOLD_RST = 7'd8;
  localparam logic [TOTAL_W-1:0]   CANDIDATE_LIMIT_RST = 17'd100;
  localparam logic [TOTAL_W-1:0]   TOTAL_MAX           = 17'h1FFFF;

  localparam logic KIND_CLEAR = 1'b0;

  typedef struct packed {
    logic ld_item;    // capture input beat, launch counter read
    logic clr_query;  // zero total and done flag
    logic sweep_wr;   // write zero at sweep address, advance sweep
    logic commit;     // write back counter if bumped, load result register
  } lcc_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic out_free;
  } lcc_sts_t;

endpackage

### hdl/lsh_collision_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsh_collision_counter
// Per-query collision counting of point ids with candidate emission.
// ----------------------------------------------------------------------------
// Every accepted beat yields exactly one result beat. The counter store is a
// single RAM with registered read: a point-id beat's counter is read in the
// accept cycle and written back in S_UPDATE when the result register is
// free. A new-query beat (tuser = 0) walks the counter store one entry a
// cycle, clearing all of it before the next beat is taken. After reset the
// same clearing pass runs with in_tready low; configuration writes are taken
// throughout. The result register decouples the two sides, so one result
// may wait while the next beat is accepted.
module lsh_collision_counter #(
  parameter int NUM_POINTS = 65536,
  parameter int MAX_TABLES = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [lcc_pkg::ID_W-1:0]          in_tdata,   // [15:0] point_id
  input  logic                              in_tuser,   // [0] kind
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [15:0] candidate_id, [32:16] candidate_total, [33] limit_reached, zero pad
  output logic [lcc_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                              out_tuser,  // [0] candidate_valid
  // configuration
  input  logic                              cfg_we,
  input  logic [lcc_pkg::CFG_AW-1:0]        cfg_addr,
  input  logic [lcc_pkg::CFG_DW-1:0]        cfg_wdata
);

  lcc_pkg::lcc_cmd_t cmd;
  lcc_pkg::lcc_sts_t sts;

  lcc_datapath #(
    .NUM_POINTS (NUM_POINTS),
    .MAX_TABLES (MAX_TABLES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_id      (in_tdata),
    .in_kind    (in_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

  lcc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_kind   (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

`ifndef SYNTHESIS
  // no beat is taken while the counter store is being cleared
  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && cmd.sweep_wr))
    else $error("input ready during clear sweep");

  // a new-query beat starts the clear sweep on the next cycle
  a_clear_starts_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == lcc_pkg::KIND_CLEAR)) |=> cmd.sweep_wr)
    else $error("clear beat did not start sweep");

  // an emitted candidate always carries a nonzero total
  a_cand_total: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata[32:16] != '0))
    else $error("candidate with zero total");

  // result register is only loaded when free
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_tvalid || out_tready))
    else $error("result overwritten");
`endif

endmodule

### hdl/lcc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hdl/lcc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcc_datapath
// Counter store, config registers, candidate total, done flag, clear sweep
// address and the output register.
// ----------------------------------------------------------------------------
module lcc_datapath #(
  parameter int NUM_POINTS = 65536,
  parameter int MAX_TABLES = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [lcc_pkg::ID_W-1:0]          in_id,
  input  logic                              in_kind,
  input  logic                              cfg_we,
  input  logic [lcc_pkg::CFG_AW-1:0]        cfg_addr,
  input  logic [lcc_pkg::CFG_DW-1:0]        cfg_wdata,
  input  lcc_pkg::lcc_cmd_t                 cmd,
  output lcc_pkg::lcc_sts_t                 sts,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic                              out_tuser,  // [0] candidate_valid
  // [15:0] candidate_id, [32:16] candidate_total, [33] limit_reached, zero pad
  output logic [lcc_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  // counters hold 0 .. MAX_TABLES+1
  localparam int CW = $clog2(MAX_TABLES + 2);
  localparam int WW = ((CW > lcc_pkg::CNT_CFG_W) ? CW : lcc_pkg::CNT_CFG_W) + 1;
  localparam int AW = $clog2(NUM_POINTS);
  localparam int PAD_W = lcc_pkg::OUT_TDATA_W - lcc_pkg::ID_W - lcc_pkg::TOTAL_W - 1;

  logic [lcc_pkg::CNT_CFG_W-1:0] num_tables_r;
  logic [lcc_pkg::CNT_CFG_W-1:0] threshold_r;
  logic [lcc_pkg::TOTAL_W-1:0]   limit_r;

  logic                          kind_r;
  logic [lcc_pkg::ID_W-1:0]      id_r;
  logic                          id_ok_r;
  logic [AW-1:0]                 sweep_r;
  logic [lcc_pkg::TOTAL_W-1:0]   total_r;
  logic                          done_r;

  logic                          out_valid_r;
  logic                          out_cand_r;
  logic [lcc_pkg::ID_W-1:0]      out_id_r;
  logic [lcc_pkg::TOTAL_W-1:0]   out_total_r;
  logic                          out_done_r;

  logic [CW-1:0]                 rdata;
  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [CW-1:0]                 ram_wdata;

  logic [WW-1:0]                 k_w;
  logic [WW-1:0]                 c_w;
  logic [WW-1:0]                 c_inc;
  logic                          bump;
  logic                          fire;
  logic [CW-1:0]                 c_new;
  logic [lcc_pkg::TOTAL_W-1:0]   total_inc;
  logic [lcc_pkg::TOTAL_W-1:0]   total_nxt;
  logic                          done_nxt;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_tables_r <= lcc_pkg::NUM_TABLES_RST;
      threshold_r  <= lcc_pkg::COUNT_THRESHOLD_RST;
      limit_r      <= lcc_pkg::CANDIDATE_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        lcc_pkg::CFG_NUM_TABLES:      num_tables_r <= cfg_wdata[lcc_pkg::CNT_CFG_W-1:0];
        lcc_pkg::CFG_COUNT_THRESHOLD: threshold_r  <= cfg_wdata[lcc_pkg::CNT_CFG_W-1:0];
        lcc_pkg::CFG_CANDIDATE_LIMIT: limit_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // read-modify-write of the fetched counter
  always_comb begin
    k_w       = (WW'(num_tables_r) > WW'(MAX_TABLES)) ? WW'(MAX_TABLES) : WW'(num_tables_r);
    c_w       = WW'(rdata);
    c_inc     = c_w + WW'(1);
    bump      = kind_r && !done_r && id_ok_r && (c_w <= k_w);
    fire      = bump && (c_inc >= WW'(threshold_r));
    c_new     = fire ? CW'(k_w + WW'(1)) : CW'(c_inc);
    total_inc = (total_r != lcc_pkg::TOTAL_MAX) ? total_r + lcc_pkg::TOTAL_W'(1) : total_r;
    total_nxt = fire ? total_inc : total_r;
    done_nxt  = done_r || (fire && (total_inc >= limit_r));
  end

  always_comb begin
    ram_we    = cmd.sweep_wr || (cmd.commit && bump);
    ram_waddr = cmd.sweep_wr ? sweep_r : AW'(id_r);
    ram_wdata = cmd.sweep_wr ? '0 : c_new;
  end

  lcc_ram #(
    .WIDTH (CW),
    .DEPTH (NUM_POINTS)
  ) u_counts (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.ld_item),
    .raddr (AW'(in_id)),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.ld_item) begin
      kind_r  <= in_kind;
      id_r    <= in_id;
      id_ok_r <= (32'(in_id) < 32'(NUM_POINTS));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r <= '0;
    end else if (cmd.sweep_wr) begin
      sweep_r <= sts.sweep_last ? '0 : sweep_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr_query) begin
      total_r <= '0;
      done_r  <= 1'b0;
    end else if (cmd.commit) begin
      total_r <= total_nxt;
      done_r  <= done_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_cand_r  <= fire;
      out_id_r    <= fire ? id_r : '0;
      out_total_r <= total_nxt;
      out_done_r  <= done_nxt;
    end
  end

  assign sts.sweep_last = (sweep_r == AW'(NUM_POINTS - 1));
  assign sts.out_free   = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_cand_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_done_r, out_total_r, out_id_r};

endmodule

### hdl/lcc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcc_ctrl
// Sequencer: post-reset clear sweep, beat acceptance, per-query clear sweep
// and result commit.
// ----------------------------------------------------------------------------
module lcc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic               in_kind,
  output logic               in_tready,
  input  lcc_pkg::lcc_sts_t  sts,
  output lcc_pkg::lcc_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_INIT,
    S_IDLE,
    S_CLEAR,
    S_UPDATE
  } state_t;

  state_t state_r;
  logic   rdy_r;

  always_comb begin
    cmd.ld_item   = rdy_r && in_tvalid;
    cmd.clr_query = rdy_r && in_tvalid && (in_kind == lcc_pkg::KIND_CLEAR);
    cmd.sweep_wr  = (state_r == S_INIT) || (state_r == S_CLEAR);
    cmd.commit    = (state_r == S_UPDATE) && sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      rdy_r   <= 1'b0;
    end else begin
      case (state_r)
        S_INIT: begin
          if (sts.sweep_last) begin
            state_r <= S_IDLE;
            rdy_r   <= 1'b1;
          end
        end
        S_IDLE: begin
          if (in_tvalid) begin
            rdy_r   <= 1'b0;
            state_r <= (in_kind == lcc_pkg::KIND_CLEAR) ? S_CLEAR : S_UPDATE;
          end
        end
        S_CLEAR: begin
          if (sts.sweep_last) begin
            state_r <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (sts.out_free) begin
            state_r <= S_IDLE;
            rdy_r   <= 1'b1;
          end
        end
        default: begin
          state_r <= S_INIT;
          rdy_r   <= 1'b0;
        end
      endcase
    end
  end

  assign in_tready = rdy_r;

endmodule
